// ===== rtl/core/cfwd_pkg.sv =====
// Shared types and constants for the CRC framed word deframer.
// No dependencies; imported by cfwd_ctrl, cfwd_dp and the top level.
`default_nettype none

package cfwd_pkg;

   // Link format and sizing
   localparam int unsigned STORE_WORDS = 32;
   localparam int unsigned MAX_BYTES   = 128;
   localparam int unsigned CAP_BYTES   =
      (MAX_BYTES < 4 * STORE_WORDS) ? MAX_BYTES : 4 * STORE_WORDS;

   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [31:0] MAGIC_RESET   = 32'h444D4E54;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd128;
   localparam logic [7:0]  CAP_LEN       = 8'(CAP_BYTES);

   // Register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_FRAME_MAGIC = 1'b0,
      CSR_MAX_LEN     = 1'b1
   } csr_idx_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_HUNT,
      ST_HEADER,
      ST_HDR_FEED,
      ST_CRC,
      ST_PAYLOAD,
      ST_PAY_FEED,
      ST_SINGLE,
      ST_REP_RD,
      ST_REP_OUT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic hdr_load;
      logic crc_load;
      logic pay_load;
      logic rep_clr;
      logic rep_rd;
      logic rep_next;
      logic out_single;
      logic out_replay;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic magic_hit;
      logic len_ok;
      logic len_zero;
      logic feed_busy;
      logic crc_match;
      logic pay_last;
      logic rep_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/cfwd_dp.sv =====
// Datapath of the deframer: config registers, byte-serial CRC16 unit,
// payload store, replay counter and the result register. Uses cfwd_pkg.
`default_nettype none

module cfwd_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   // config port
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [31:0]       csr_wdata,
   // input word
   input  wire logic [31:0]       req_rx_word,
   // controller interface
   input  wire cfwd_pkg::cmd_type cmd,
   output cfwd_pkg::sts_type      sts,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [15:0]            rsp_pkt_type,
   output logic [7:0]             rsp_pkt_len,
   output logic [31:0]            rsp_data_word,
   output logic [4:0]             rsp_word_index,
   output logic                   rsp_crc_ok,
   output logic                   rsp_last
);
   import cfwd_pkg::*;

   // one CCITT byte step, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

   logic [31:0] magic_ff, magic_in;
   logic [7:0]  max_len_ff, max_len_in;
   logic [15:0] type_ff, type_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] exp_crc_ff, exp_crc_in;
   logic [15:0] crc_ff, crc_in;
   logic [31:0] feed_ff, feed_in;
   logic [2:0]  feed_cnt_ff, feed_cnt_in;
   logic [5:0]  seen_ff, seen_in;
   logic        pay_last_ff, pay_last_in;
   logic [4:0]  rep_idx_ff, rep_idx_in;
   logic [31:0] rd_data_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_type_ff, out_type_in;
   logic [7:0]  out_len_ff, out_len_in;
   logic [31:0] out_data_ff, out_data_in;
   logic [4:0]  out_idx_ff, out_idx_in;
   logic        out_ok_ff, out_ok_in;
   logic        out_last_ff, out_last_in;

   logic [31:0] store_mem [STORE_WORDS];

   logic [7:0]  limit;
   logic [5:0]  need;
   logic [7:0]  rem;
   logic [2:0]  nbytes;
   logic [31:0] keep;
   logic        out_free;

   // effective length limit and word count of the frame
   assign limit = (max_len_ff > CAP_LEN) ? CAP_LEN : max_len_ff;
   assign need  = 6'((9'(len_ff) + 9'd3) >> 2);

   // bytes of the current payload word that belong to the frame
   assign rem    = len_ff - {seen_ff, 2'b00};
   assign nbytes = (rem > 8'd4) ? 3'd4 : rem[2:0];
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         keep[8*j +: 8] = (8'(j) < rem) ? req_rx_word[8*j +: 8] : 8'h00;
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   // status to the controller
   always_comb begin
      sts.magic_hit = (req_rx_word == magic_ff);
      sts.len_ok    = (req_rx_word[15:0] <= {8'h00, limit});
      sts.len_zero  = (len_ff == 8'd0);
      sts.feed_busy = (feed_cnt_ff != 3'd0);
      sts.crc_match = (crc_ff == exp_crc_ff);
      sts.pay_last  = pay_last_ff;
      sts.rep_last  = ({1'b0, rep_idx_ff} + 6'd1 == need);
      sts.out_free  = out_free;
   end

   // next-state logic
   always_comb begin
      magic_in    = magic_ff;
      max_len_in  = max_len_ff;
      type_in     = type_ff;
      len_in      = len_ff;
      exp_crc_in  = exp_crc_ff;
      crc_in      = crc_ff;
      feed_in     = feed_ff;
      feed_cnt_in = feed_cnt_ff;
      seen_in     = seen_ff;
      pay_last_in = pay_last_ff;
      rep_idx_in  = rep_idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_type_in = out_type_ff;
      out_len_in  = out_len_ff;
      out_data_in = out_data_ff;
      out_idx_in  = out_idx_ff;
      out_ok_in   = out_ok_ff;
      out_last_in = out_last_ff;

      // config writes
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_FRAME_MAGIC: magic_in   = csr_wdata;
            CSR_MAX_LEN:     max_len_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      // CRC unit: one byte per cycle
      if (feed_cnt_ff != 3'd0) begin
         crc_in      = crc_byte(crc_ff, feed_ff[7:0]);
         feed_in     = {8'h00, feed_ff[31:8]};
         feed_cnt_in = feed_cnt_ff - 3'd1;
      end

      // header: type low byte, then length low and high bytes
      if (cmd.hdr_load) begin
         type_in     = req_rx_word[31:16];
         len_in      = req_rx_word[7:0];
         crc_in      = CRC_INIT;
         feed_in     = {8'h00, req_rx_word[15:8], req_rx_word[7:0], req_rx_word[23:16]};
         feed_cnt_in = 3'd3;
      end

      if (cmd.crc_load) begin
         exp_crc_in = req_rx_word[15:0];
         seen_in    = 6'd0;
      end

      if (cmd.pay_load) begin
         feed_in     = keep;
         feed_cnt_in = nbytes;
         seen_in     = seen_ff + 6'd1;
         pay_last_in = (seen_ff + 6'd1 == need);
      end

      // replay counter
      if (cmd.rep_clr) begin
         rep_idx_in = 5'd0;
      end else if (cmd.rep_next) begin
         rep_idx_in = rep_idx_ff + 5'd1;
      end

      // result register, type and length held with the transaction
      if (cmd.out_single) begin
         out_valid_in = 1'b1;
         out_type_in  = type_ff;
         out_len_in   = len_ff;
         out_data_in  = 32'h0;
         out_idx_in   = 5'd0;
         out_ok_in    = (crc_ff == exp_crc_ff);
         out_last_in  = 1'b1;
      end else if (cmd.out_replay) begin
         out_valid_in = 1'b1;
         out_type_in  = type_ff;
         out_len_in   = len_ff;
         out_data_in  = rd_data_ff;
         out_idx_in   = rep_idx_ff;
         out_ok_in    = 1'b1;
         out_last_in  = ({1'b0, rep_idx_ff} + 6'd1 == need);
      end
   end

   // control and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= MAGIC_RESET;
         max_len_ff   <= MAX_LEN_RESET;
         type_ff      <= 16'h0;
         len_ff       <= 8'h0;
         exp_crc_ff   <= 16'h0;
         crc_ff       <= CRC_INIT;
         feed_cnt_ff  <= 3'd0;
         seen_ff      <= 6'd0;
         pay_last_ff  <= 1'b0;
         rep_idx_ff   <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         magic_ff     <= magic_in;
         max_len_ff   <= max_len_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         exp_crc_ff   <= exp_crc_in;
         crc_ff       <= crc_in;
         feed_cnt_ff  <= feed_cnt_in;
         seen_ff      <= seen_in;
         pay_last_ff  <= pay_last_in;
         rep_idx_ff   <= rep_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      feed_ff     <= feed_in;
      out_type_ff <= out_type_in;
      out_len_ff  <= out_len_in;
      out_data_ff <= out_data_in;
      out_idx_ff  <= out_idx_in;
      out_ok_ff   <= out_ok_in;
      out_last_ff <= out_last_in;
   end

   // payload store: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.pay_load) begin
         store_mem[seen_ff[4:0]] <= keep;
      end
      if (cmd.rep_rd) begin
         rd_data_ff <= store_mem[rep_idx_ff];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pkt_type   = out_type_ff;
   assign rsp_pkt_len    = out_len_ff;
   assign rsp_data_word  = out_data_ff;
   assign rsp_word_index = out_idx_ff;
   assign rsp_crc_ok     = out_ok_ff;
   assign rsp_last       = out_last_ff;

`ifndef ASSERT_OFF
   // a payload word never lands while the CRC unit still works on bytes
   a_no_feed_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.pay_load |-> (feed_cnt_ff == 3'd0))
      else $error("payload loaded while CRC feed busy");

   // the CRC unit never holds more than one word of bytes
   a_feed_bound: assert property (@(posedge clock) disable iff (reset)
      feed_cnt_ff <= 3'd4)
      else $error("CRC feed count out of range");

   // a pending result is never overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_single || cmd.out_replay) |-> out_free)
      else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cfwd_ctrl.sv =====
// Controller state machine of the deframer: frame parsing phases,
// CRC feed waits and payload replay. Uses cfwd_pkg.
`default_nettype none

module cfwd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cfwd_pkg::sts_type sts,
   output cfwd_pkg::cmd_type      cmd
);
   import cfwd_pkg::*;

   state_type state_ff, state_in;
   logic      take;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign take = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_HUNT: begin
            req_ready = 1'b1;
            if (take && sts.magic_hit) state_in = ST_HEADER;
         end
         ST_HEADER: begin
            req_ready = 1'b1;
            if (take) begin
               if (sts.len_ok) begin
                  cmd.hdr_load = 1'b1;
                  state_in     = ST_HDR_FEED;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_HDR_FEED: begin
            if (!sts.feed_busy) state_in = ST_CRC;
         end
         ST_CRC: begin
            req_ready = 1'b1;
            if (take) begin
               cmd.crc_load = 1'b1;
               state_in     = sts.len_zero ? ST_SINGLE : ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            req_ready = 1'b1;
            if (take) begin
               cmd.pay_load = 1'b1;
               state_in     = ST_PAY_FEED;
            end
         end
         ST_PAY_FEED: begin
            if (!sts.feed_busy) begin
               if (!sts.pay_last) begin
                  state_in = ST_PAYLOAD;
               end else if (sts.crc_match) begin
                  cmd.rep_clr = 1'b1;
                  state_in    = ST_REP_RD;
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_SINGLE: begin
            if (sts.out_free) begin
               cmd.out_single = 1'b1;
               state_in       = ST_HUNT;
            end
         end
         ST_REP_RD: begin
            cmd.rep_rd = 1'b1;
            state_in   = ST_REP_OUT;
         end
         ST_REP_OUT: begin
            if (sts.out_free) begin
               cmd.out_replay = 1'b1;
               if (sts.rep_last) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.rep_next = 1'b1;
                  state_in     = ST_REP_RD;
               end
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

`ifndef ASSERT_OFF
   // a store read always follows a cleared or advanced replay index
   a_rep_order: assert property (@(posedge clock) disable iff (reset)
      cmd.rep_rd |-> ($past(cmd.rep_clr) || $past(cmd.rep_next)))
      else $error("replay read without index update");

   // only one result source per cycle
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_single && cmd.out_replay))
      else $error("two result loads in one cycle");

   // a single result load ends the frame and returns to the hunt
   a_out_next: assert property (@(posedge clock) disable iff (reset)
      cmd.out_single |=> (state_ff == ST_HUNT))
      else $error("single result did not end the frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/crc_framed_word_deframer_unit.sv =====
// Top level of the CRC framed word deframer: ties the controller to the
// datapath. Uses cfwd_pkg, cfwd_ctrl and cfwd_dp.
// Hunts for the magic word, then takes a header, a CRC word and the payload words of a
// frame. After the header the input is held while the CRC16 unit folds the header's three
// bytes, and after each payload word while it folds that word's bytes in the frame:
// the CRC16 unit folds one byte per cycle. At frame end a bad or empty frame gives one
// result; a good frame replays its stored words, each passing the registered read of the
// payload store before it enters the result register. A pending result does not block
// the next frame's hunt. No clearing pass after reset.
`default_nettype none

module crc_framed_word_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   // input words
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_rx_word,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pkt_type,
   output logic [7:0]       rsp_pkt_len,
   output logic [31:0]      rsp_data_word,
   output logic [4:0]       rsp_word_index,
   output logic             rsp_crc_ok,
   output logic             rsp_last
);
   import cfwd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // phase controller
   cfwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // CRC, store and result datapath
   cfwd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_rx_word    (req_rx_word),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pkt_type   (rsp_pkt_type),
      .rsp_pkt_len    (rsp_pkt_len),
      .rsp_data_word  (rsp_data_word),
      .rsp_word_index (rsp_word_index),
      .rsp_crc_ok     (rsp_crc_ok),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== dv/crc_framed_word_deframer_unit_tb.sv =====
// Self-checking testbench for crc_framed_word_deframer_unit: directed frames, then random
// framed link traffic under several register settings, checked against an in-bench predictor.
// Depends on cfwd_pkg and the crc_framed_word_deframer_unit RTL only.
`timescale 1ns / 1ps

module crc_framed_word_deframer_unit_tb;
   import cfwd_pkg::*;

   localparam int unsigned RUN_LIMIT     = 400000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned PHASE_ITEMS   = 80;

   typedef enum logic [1:0] {
      PARSE_HUNT,
      PARSE_HEADER,
      PARSE_CRC,
      PARSE_PAYLOAD
   } parse_type;

   typedef struct packed {
      logic [15:0] pkt_type;
      logic [7:0]  pkt_len;
      logic [31:0] data_word;
      logic [4:0]  word_index;
      logic        crc_ok;
      logic        last;
   } result_type;

   // one directed step: a link word, or a CRC word filled in from the frame around it
   typedef struct {
      logic [31:0] word;
      logic        fill_crc;
      logic        typed;
      result_type  want;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_rx_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_pkt_type;
   logic [7:0]  rsp_pkt_len;
   logic [31:0] rsp_data_word;
   logic [4:0]  rsp_word_index;
   logic        rsp_crc_ok;
   logic        rsp_last;

   // deframer mirror: register copies and parse state
   logic [31:0] cfg_magic;
   logic [7:0]  cfg_max_len;
   parse_type   parse_ph;
   logic [15:0] fr_type;
   logic [7:0]  fr_len;
   logic [15:0] fr_crc_want;
   logic [15:0] fr_crc_run;
   logic [5:0]  fr_words;
   logic [31:0] payload_copy [STORE_WORDS];
   result_type  results_due [$];

   step_row_type dir_table [$];
   bit idle_on;
   int fail_count;
   int cycle_count;
   int words_accepted;
   int frames_sent;
   int dropped_sent;
   int results_checked;
   int bad_seen;

   crc_framed_word_deframer_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_word    (req_rx_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pkt_type   (rsp_pkt_type),
      .rsp_pkt_len    (rsp_pkt_len),
      .rsp_data_word  (rsp_data_word),
      .rsp_word_index (rsp_word_index),
      .rsp_crc_ok     (rsp_crc_ok),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("crc_framed_word_deframer_unit regression: fail");
         $finish;
      end
   end

   // CRC16-CCITT, one byte MSB first
   function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   // checksum a sender puts in the CRC word of a frame
   function automatic logic [15:0] frame_crc(logic [15:0] ftype, logic [15:0] len,
                                             logic [31:0] words [$]);
      logic [15:0] c;
      c = crc16_fold(CRC_INIT, ftype[7:0]);
      c = crc16_fold(c, len[7:0]);
      c = crc16_fold(c, len[15:8]);
      for (int k = 0; k < len; k++)
         c = crc16_fold(c, 8'(words[k >> 2] >> (8 * (k & 3))));
      return c;
   endfunction

   function automatic result_type mk_result(logic [15:0] t, logic [7:0] l, logic [31:0] d,
                                            logic [4:0] x, logic ok, logic lst);
      return {t, l, d, x, ok, lst};
   endfunction

   // advance the mirror by one link word, queue the results it releases
   function automatic void deframe_word(logic [31:0] w);
      logic [15:0] len16;
      logic [7:0]  lim;
      logic [5:0]  need;
      logic [31:0] keep;
      lim = (cfg_max_len > CAP_LEN) ? CAP_LEN : cfg_max_len;
      case (parse_ph)
         PARSE_HUNT: begin
            if (w == cfg_magic)
               parse_ph = PARSE_HEADER;
         end
         PARSE_HEADER: begin
            len16 = w[15:0];
            if (len16 > {8'h00, lim}) begin
               parse_ph = PARSE_HUNT;
            end else begin
               fr_type    = w[31:16];
               fr_len     = len16[7:0];
               fr_crc_run = crc16_fold(CRC_INIT, fr_type[7:0]);
               fr_crc_run = crc16_fold(fr_crc_run, len16[7:0]);
               fr_crc_run = crc16_fold(fr_crc_run, len16[15:8]);
               parse_ph   = PARSE_CRC;
            end
         end
         PARSE_CRC: begin
            fr_crc_want = w[15:0];
            fr_words    = '0;
            if (fr_len == 8'd0) begin
               parse_ph = PARSE_HUNT;
               results_due.push_back(mk_result(fr_type, fr_len, '0, '0,
                                               fr_crc_run == fr_crc_want, 1'b1));
            end else begin
               parse_ph = PARSE_PAYLOAD;
            end
         end
         default: begin
            need = 6'(({1'b0, fr_len} + 9'd3) >> 2);
            keep = '0;
            // bytes past the frame length are neither checksummed nor kept
            for (int j = 0; j < 4; j++) begin
               if (({fr_words, 2'b00} + j) < fr_len) begin
                  keep[8*j +: 8] = w[8*j +: 8];
                  fr_crc_run     = crc16_fold(fr_crc_run, w[8*j +: 8]);
               end
            end
            if (fr_words < STORE_WORDS)
               payload_copy[fr_words[4:0]] = keep;
            fr_words = fr_words + 6'd1;
            if (fr_words >= need) begin
               parse_ph = PARSE_HUNT;
               if (fr_crc_run != fr_crc_want) begin
                  results_due.push_back(mk_result(fr_type, fr_len, '0, '0, 1'b0, 1'b1));
               end else begin
                  for (int i = 0; i < need; i++)
                     results_due.push_back(mk_result(fr_type, fr_len, payload_copy[i],
                                                     5'(i), 1'b1, (i + 1) == need));
               end
            end
         end
      endcase
   endfunction

   // one input transaction, with a random gap ahead of it
   task automatic send_word(logic [31:0] w);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_word <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      deframe_word(w);
      words_accepted++;
   endtask

   // wait out every expected result, then the block's own tail
   task automatic drain();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; upper bits of the length write are don't-care
   task automatic apply_settings(logic [31:0] magic, logic [7:0] max_len);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_MAGIC;
      csr_wdata <= magic;
      @(posedge clock);
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= {24'($urandom), max_len};
      @(posedge clock);
      csr_we      <= 1'b0;
      cfg_magic   = magic;
      cfg_max_len = max_len;
   endtask

   // mostly well-formed frames, some oversize headers, some broken sequences
   task automatic random_traffic(int budget);
      int sent;
      int pick;
      int lim;
      int len;
      int need;
      logic [15:0] ftype;
      logic [15:0] crc;
      logic [31:0] noise;
      logic [31:0] words [$];
      sent = 0;
      while (sent < budget) begin
         idle_on = ($urandom_range(0, 4) != 0);
         lim  = (cfg_max_len > CAP_LEN) ? CAP_LEN : cfg_max_len;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 2) == 0) begin
               noise = $urandom;
               if (noise == cfg_magic)
                  noise ^= 32'h1;
               send_word(noise);
            end
            ftype = 16'($urandom);
            case ($urandom_range(0, 9))
               0:       len = 0;
               1:       len = lim;
               default: len = $urandom_range(0, (lim < 16) ? lim : 16);
            endcase
            need  = (len + 3) / 4;
            words = {};
            for (int k = 0; k < need; k++)
               words.push_back($urandom);
            crc = frame_crc(ftype, 16'(len), words);
            if ($urandom_range(0, 3) == 0)
               crc ^= 16'(1 << $urandom_range(0, 15));
            send_word(cfg_magic);
            send_word({ftype, 16'(len)});
            send_word({16'($urandom), crc});
            foreach (words[k])
               send_word(words[k]);
            sent += 3 + need;
            frames_sent++;
         end else if (pick < 85) begin
            len = $urandom_range(0, 1) ? $urandom_range(lim + 1, lim + 8)
                                       : $urandom_range(lim + 1, 65535);
            send_word(cfg_magic);
            send_word({16'($urandom), 16'(len)});
            sent += 2;
            dropped_sent++;
         end else begin
            send_word(cfg_magic);
            sent++;
            repeat ($urandom_range(1, 3)) begin
               send_word($urandom);
               sent++;
            end
         end
      end
   endtask

   // result side: random stalls, compare each transaction with the oldest expectation
   initial begin
      result_type got;
      result_type want;
      int gap;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = idle_on ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got = {rsp_pkt_type, rsp_pkt_len, rsp_data_word, rsp_word_index, rsp_crc_ok,
                rsp_last};
         results_checked++;
         if (!got.crc_ok)
            bad_seen++;
         if (results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: type %h len %0d data %h index %0d ok %b last %b",
                        got.pkt_type, got.pkt_len, got.data_word, got.word_index,
                        got.crc_ok, got.last);
         end else begin
            want = results_due.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"result mismatch (expected/actual): type %h/%h len %0d/%0d ",
                            "data %h/%h index %0d/%0d ok %b/%b last %b/%b"},
                           want.pkt_type, got.pkt_type, want.pkt_len, got.pkt_len,
                           want.data_word, got.data_word, want.word_index, got.word_index,
                           want.crc_ok, got.crc_ok, want.last, got.last);
            end
         end
      end
   end

   // input side: reset, directed table, then random phases
   initial begin
      logic [31:0] word;
      logic [15:0] len;
      logic [31:0] pay [$];
      int need;
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_index   <= CSR_FRAME_MAGIC;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_rx_word <= '0;
      cycle_count     = 0;
      fail_count      = 0;
      words_accepted  = 0;
      frames_sent     = 0;
      dropped_sent    = 0;
      results_checked = 0;
      bad_seen        = 0;
      idle_on         = 1'b1;
      cfg_magic   = MAGIC_RESET;
      cfg_max_len = MAX_LEN_RESET;
      parse_ph    = PARSE_HUNT;
      fr_type     = '0;
      fr_len      = '0;
      fr_crc_want = '0;
      fr_crc_run  = CRC_INIT;
      fr_words    = '0;

      // noise while hunting
      dir_table.push_back(step_row_type'{32'h0000_0000, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hFFFF_FFFF, 1'b0, 1'b0, '0});
      // empty frame, all-zero header, matching checksum
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h0000_0000, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h0000_CC9C, 1'b0, 1'b1,
                          mk_result(16'h0000, 8'd0, '0, '0, 1'b1, 1'b1)});
      // empty frame, wrong checksum: flagged bad
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hFF00_0000, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hFFFF_0000, 1'b0, 1'b1,
                          mk_result(16'hFF00, 8'd0, '0, '0, 1'b0, 1'b1)});
      // over-limit lengths: one past the limit, low byte zero, all ones
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h1234_0081, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h00FF_0100, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hABCD_FFFF, 1'b0, 1'b0, '0});
      // magic taken as a header is too long and dropped
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      // good 5-byte frame carrying the magic as payload, partial last word
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hFFFF_0005, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h0000_0000, 1'b1, 1'b0, '0});
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hFFFF_FFFF, 1'b0, 1'b0, '0});
      // one-word frame with an arbitrary checksum
      dir_table.push_back(step_row_type'{MAGIC_RESET, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h5A5A_0004, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'h0000_1234, 1'b0, 1'b0, '0});
      dir_table.push_back(step_row_type'{32'hDEAD_BEEF, 1'b0, 1'b0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_table.size(); i++) begin
         word = dir_table[i].word;
         if (dir_table[i].fill_crc) begin
            len  = dir_table[i-1].word[15:0];
            need = (len + 3) / 4;
            pay  = {};
            for (int k = 1; k <= need; k++)
               pay.push_back(dir_table[i+k].word);
            word = {16'h0000, frame_crc(dir_table[i-1].word[31:16], len, pay)};
         end
         send_word(word);
         if (dir_table[i].typed) begin
            if (results_due.size() != 0)
               void'(results_due.pop_back());
            results_due.push_back(dir_table[i].want);
         end
      end
      drain();

      // random phases across register settings, extremes included
      apply_settings($urandom, 8'd128);
      random_traffic(PHASE_ITEMS);
      drain();
      apply_settings(32'hFFFF_FFFF, 8'd0);
      random_traffic(PHASE_ITEMS);
      drain();
      apply_settings(32'h0000_0000, 8'd255);
      random_traffic(PHASE_ITEMS);
      drain();
      apply_settings($urandom, 8'($urandom_range(1, 127)));
      random_traffic(PHASE_ITEMS);
      drain();
      apply_settings(MAGIC_RESET, 8'd4);
      random_traffic(PHASE_ITEMS);
      drain();

      fail_count += results_due.size();
      $display("covered %0d link words: %0d random frames, %0d oversize headers, five settings",
               words_accepted, frames_sent, dropped_sent);
      $display("checked %0d results, %0d of them bad-checksum frames, %0d failures",
               results_checked, bad_seen, fail_count);
      if (fail_count == 0)
         $display("crc_framed_word_deframer_unit regression: pass");
      else
         $display("crc_framed_word_deframer_unit regression: fail");
      $finish;
   end

endmodule
